/* rtl/crc8hfd_pkg.sv */
// Types and constants shared by the header-checked frame deframer.
// Holds the channel payload structs, the parser phase enum and the command codes.
// Depends on nothing else.
package crc8hfd_pkg;

   // Framing.
   localparam logic [7:0] SOF_BYTE        = 8'hA5;
   localparam logic [7:0] CRC8_POLY_REFL  = 8'h8C;
   localparam logic [7:0] CRC8_SEED_RESET = 8'hFF;

   // The record decode never looks past payload byte 15, so eight 16-bit words are read.
   localparam int unsigned DRAIN_AW    = 3;
   localparam int unsigned DRAIN_WORDS = 2 ** DRAIN_AW;
   localparam int unsigned NUM_VALUES  = 7;

   // Known commands and the payload length each one must carry.
   localparam logic [15:0] CMD_GAME_STATUS  = 16'h0001;
   localparam logic [15:0] CMD_ROBOT_STATUS = 16'h0201;
   localparam logic [15:0] CMD_POWER_HEAT   = 16'h0202;
   localparam logic [15:0] CMD_SHOT         = 16'h0207;
   localparam logic [15:0] CMD_ALLOWANCE    = 16'h0208;
   localparam logic [15:0] CMD_REMOTE_INPUT = 16'h0304;
   localparam logic [15:0] CMD_CENTER_GAIN  = 16'h0101;

   localparam logic [15:0] LEN_GAME_STATUS  = 16'd11;
   localparam logic [15:0] LEN_ROBOT_STATUS = 16'd13;
   localparam logic [15:0] LEN_POWER_HEAT   = 16'd16;
   localparam logic [15:0] LEN_SHOT         = 16'd7;
   localparam logic [15:0] LEN_ALLOWANCE    = 16'd6;
   localparam logic [15:0] LEN_REMOTE_INPUT = 16'd12;
   localparam logic [15:0] LEN_CENTER_GAIN  = 16'd4;

   // Record kinds as they appear on the result channel.
   localparam logic [2:0] KIND_GAME_STATUS  = 3'd0;
   localparam logic [2:0] KIND_ROBOT_STATUS = 3'd1;
   localparam logic [2:0] KIND_POWER_HEAT   = 3'd2;
   localparam logic [2:0] KIND_SHOT         = 3'd3;
   localparam logic [2:0] KIND_ALLOWANCE    = 3'd4;
   localparam logic [2:0] KIND_REMOTE_INPUT = 3'd5;
   localparam logic [2:0] KIND_CENTER_GAIN  = 3'd6;

   // Field details.
   localparam logic [3:0] PROGRESS_RUNNING = 4'h4;
   localparam logic [7:0] ID_BLUE_BASE     = 8'd100;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_BODY
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_data_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [31:0] value_0;
      logic [31:0] value_1;
      logic [31:0] value_2;
      logic [31:0] value_3;
      logic [31:0] value_4;
      logic [31:0] value_5;
      logic [31:0] value_6;
   } rsp_data_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] kind;
   } rec_sel_type;

endpackage

/* rtl/crc8_header_frame_deframer.sv */
// Header-checked frame deframer: start byte hunt, CRC8 header check, payload store.
// Payload bytes sit in a word memory that is read back after the frame to build one record.
// Depends on crc8hfd_pkg.
//
//   Port group   Direction  Handshake          Carries
//   req_*        in         valid / stall      one stream byte and its buffer end flag
//   rsp_*        out        valid / stall      one decoded record (kind and seven values)
//   csr_*        in         write enable only  CRC8 seed
//
// One byte is accepted every cycle while req_stall is low. After the last byte of a frame
// that yields a record, the memory is read out one 16-bit word per cycle into rdata_ff,
// each word is folded into the values, and the record then shows on rsp_valid. req_stall
// rises only on a frame's last byte, and only while the previous record is still being
// read out or still waits on rsp_stall. Reset is synchronous; the payload memory needs no
// clearing because a record only reads bytes written by its own frame.
module crc8_header_frame_deframer #(
   parameter int unsigned PAYLOAD_BYTES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  crc8hfd_pkg::req_data_type   req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output crc8hfd_pkg::rsp_data_type   rsp_data,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data
);

   localparam int unsigned WordDepth = (PAYLOAD_BYTES + 1) / 2;
   localparam int unsigned WordAw    = $clog2(WordDepth);
   localparam int unsigned DrainAw   = crc8hfd_pkg::DRAIN_AW;
   localparam logic [DrainAw-1:0] DrainLast = DrainAw'(crc8hfd_pkg::DRAIN_WORDS - 1);

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ crc8hfd_pkg::CRC8_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   function automatic crc8hfd_pkg::rec_sel_type rec_select(input logic [15:0] cmd,
                                                           input logic [15:0] len);
      crc8hfd_pkg::rec_sel_type r;
      r.hit  = 1'b0;
      r.kind = crc8hfd_pkg::KIND_GAME_STATUS;
      unique case (cmd)
         crc8hfd_pkg::CMD_GAME_STATUS: begin
            r.hit  = (len == crc8hfd_pkg::LEN_GAME_STATUS);
            r.kind = crc8hfd_pkg::KIND_GAME_STATUS;
         end
         crc8hfd_pkg::CMD_ROBOT_STATUS: begin
            r.hit  = (len == crc8hfd_pkg::LEN_ROBOT_STATUS);
            r.kind = crc8hfd_pkg::KIND_ROBOT_STATUS;
         end
         crc8hfd_pkg::CMD_POWER_HEAT: begin
            r.hit  = (len == crc8hfd_pkg::LEN_POWER_HEAT);
            r.kind = crc8hfd_pkg::KIND_POWER_HEAT;
         end
         crc8hfd_pkg::CMD_SHOT: begin
            r.hit  = (len == crc8hfd_pkg::LEN_SHOT);
            r.kind = crc8hfd_pkg::KIND_SHOT;
         end
         crc8hfd_pkg::CMD_ALLOWANCE: begin
            r.hit  = (len == crc8hfd_pkg::LEN_ALLOWANCE);
            r.kind = crc8hfd_pkg::KIND_ALLOWANCE;
         end
         crc8hfd_pkg::CMD_REMOTE_INPUT: begin
            r.hit  = (len == crc8hfd_pkg::LEN_REMOTE_INPUT);
            r.kind = crc8hfd_pkg::KIND_REMOTE_INPUT;
         end
         crc8hfd_pkg::CMD_CENTER_GAIN: begin
            r.hit  = (len == crc8hfd_pkg::LEN_CENTER_GAIN);
            r.kind = crc8hfd_pkg::KIND_CENTER_GAIN;
         end
         default: begin
            r.hit = 1'b0;
         end
      endcase
      return r;
   endfunction

   // Parser state.
   crc8hfd_pkg::phase_type phase_ff, phase_in;
   logic [16:0]            pos_ff, pos_in;
   logic [15:0]            len_ff, len_in;
   logic [7:0]             crc_ff, crc_in;
   logic                   hdr_good_ff, hdr_good_in;
   logic [15:0]            cmd_ff, cmd_in;
   logic [7:0]             seed_ff;
   logic [7:0]             lo_hold_ff;

   // Payload memory and readout.
   logic [15:0]            payload_mem [WordDepth];
   logic                   mem_we;
   logic [WordAw-1:0]      mem_waddr;
   logic [15:0]            mem_wdata;
   logic                   drain_busy_ff;
   logic [DrainAw-1:0]     drain_cnt_ff;
   logic                   rd_vld_ff;
   logic [DrainAw-1:0]     rd_idx_ff;
   logic [15:0]            rdata_ff;
   logic [7:0]             w_lo, w_hi;

   // Result.
   logic                   rsp_valid_ff;
   logic [2:0]             kind_ff;
   logic [31:0]            val_ff [crc8hfd_pkg::NUM_VALUES];
   logic [31:0]            val_in [crc8hfd_pkg::NUM_VALUES];

   logic                   req_fire;
   logic                   frame_last;
   logic [16:0]            pay_idx;
   logic                   pay_store;
   crc8hfd_pkg::rec_sel_type rec_sel;
   logic                   rec_due;
   logic                   drain_start;
   logic [7:0]             rx_b;

   assign rx_b       = req_data.rx_byte;
   assign req_fire   = req_valid && !req_stall;
   assign frame_last = (phase_ff == crc8hfd_pkg::PH_BODY)
                       && (pos_ff >= ({1'b0, len_ff} + 17'd8));
   assign pay_idx    = pos_ff - 17'd7;
   assign pay_store  = (phase_ff == crc8hfd_pkg::PH_BODY) && (pos_ff >= 17'd7)
                       && (pos_ff < ({1'b0, len_ff} + 17'd7))
                       && (pay_idx < 17'(PAYLOAD_BYTES));
   assign rec_sel    = rec_select(cmd_ff, len_ff);
   assign rec_due    = frame_last && hdr_good_ff && rec_sel.hit;

   // The readout must start right after the last byte so that it stays ahead of the next
   // frame's payload writes; hold that byte back while the previous record is in the way.
   assign req_stall   = rec_due && (drain_busy_ff || rd_vld_ff || (rsp_valid_ff && rsp_stall));
   assign drain_start = req_fire && rec_due;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (phase_ff)
            crc8hfd_pkg::PH_HUNT: begin
               if (rx_b == crc8hfd_pkg::SOF_BYTE) begin
                  phase_in = crc8hfd_pkg::PH_HEADER;
               end
            end
            crc8hfd_pkg::PH_HEADER: begin
               if (pos_ff >= 17'd4) begin
                  phase_in = crc8hfd_pkg::PH_BODY;
               end
            end
            crc8hfd_pkg::PH_BODY: begin
               if (frame_last) begin
                  phase_in = crc8hfd_pkg::PH_HUNT;
               end
            end
            default: begin
               phase_in = crc8hfd_pkg::PH_HUNT;
            end
         endcase
         if (req_data.buffer_end) begin
            phase_in = crc8hfd_pkg::PH_HUNT;
         end
      end
   end

   // Parser datapath.
   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      hdr_good_in = hdr_good_ff;
      cmd_in      = cmd_ff;
      if (req_fire) begin
         unique case (phase_ff)
            crc8hfd_pkg::PH_HUNT: begin
               if (rx_b == crc8hfd_pkg::SOF_BYTE) begin
                  crc_in = crc8_byte(seed_ff, rx_b);
                  pos_in = 17'd1;
               end
            end
            crc8hfd_pkg::PH_HEADER: begin
               if (pos_ff == 17'd1) begin
                  len_in = {8'h00, rx_b};
               end else if (pos_ff == 17'd2) begin
                  len_in = {rx_b, len_ff[7:0]};
               end
               if (pos_ff < 17'd4) begin
                  crc_in = crc8_byte(crc_ff, rx_b);
                  pos_in = pos_ff + 17'd1;
               end else begin
                  hdr_good_in = (crc_ff == rx_b);
                  pos_in      = 17'd5;
               end
            end
            crc8hfd_pkg::PH_BODY: begin
               if (pos_ff == 17'd5) begin
                  cmd_in = {8'h00, rx_b};
               end else if (pos_ff == 17'd6) begin
                  cmd_in = {rx_b, cmd_ff[7:0]};
               end
               if (frame_last) begin
                  pos_in = '0;
               end else begin
                  pos_in = pos_ff + 17'd1;
               end
            end
            default: begin
               pos_in = '0;
            end
         endcase
         // The position is always zero while hunting, so a buffer end can clear it freely.
         if (req_data.buffer_end) begin
            pos_in = '0;
         end
      end
   end

   // Bytes are packed in pairs; an odd byte completes the word started by the even one.
   assign mem_we    = req_fire && pay_store;
   assign mem_waddr = pay_idx[WordAw:1];
   assign mem_wdata = pay_idx[0] ? {rx_b, lo_hold_ff} : {8'h00, rx_b};

   assign w_lo = rdata_ff[7:0];
   assign w_hi = rdata_ff[15:8];

   // Each word read back drops its bytes into the value fields of the current record kind.
   always_comb begin
      val_in = val_ff;
      if (drain_start) begin
         val_in = '{default: '0};
      end else if (rd_vld_ff) begin
         unique case (kind_ff)
            crc8hfd_pkg::KIND_GAME_STATUS: begin
               if (rd_idx_ff == 3'd0) begin
                  val_in[0] = {31'b0, w_lo[7:4] == crc8hfd_pkg::PROGRESS_RUNNING};
               end
            end
            crc8hfd_pkg::KIND_ROBOT_STATUS: begin
               unique case (rd_idx_ff)
                  3'd0: begin
                     val_in[0] = {24'b0, w_lo};
                     val_in[1] = {31'b0, w_lo < crc8hfd_pkg::ID_BLUE_BASE};
                  end
                  3'd1: val_in[2] = {16'b0, w_hi, w_lo};
                  3'd3: val_in[3] = {16'b0, w_hi, w_lo};
                  3'd4: val_in[4] = {16'b0, w_hi, w_lo};
                  3'd5: val_in[5] = {16'b0, w_hi, w_lo};
                  3'd6: val_in[6] = {29'b0, w_lo[2:0]};
                  default: ;
               endcase
            end
            crc8hfd_pkg::KIND_POWER_HEAT: begin
               unique case (rd_idx_ff)
                  3'd2: val_in[1][15:0]  = {w_hi, w_lo};
                  3'd3: val_in[1][31:16] = {w_hi, w_lo};
                  3'd4: val_in[0] = {16'b0, w_hi, w_lo};
                  3'd5: val_in[2] = {16'b0, w_hi, w_lo};
                  3'd7: val_in[3] = {16'b0, w_hi, w_lo};
                  default: ;
               endcase
            end
            crc8hfd_pkg::KIND_SHOT: begin
               unique case (rd_idx_ff)
                  3'd1: begin
                     val_in[1]      = {24'b0, w_lo};
                     val_in[0][7:0] = w_hi;
                  end
                  3'd2: val_in[0][23:8]  = {w_hi, w_lo};
                  3'd3: val_in[0][31:24] = w_lo;
                  default: ;
               endcase
            end
            crc8hfd_pkg::KIND_ALLOWANCE: begin
               unique case (rd_idx_ff)
                  3'd0: val_in[0] = {16'b0, w_hi, w_lo};
                  3'd1: val_in[1] = {16'b0, w_hi, w_lo};
                  default: ;
               endcase
            end
            crc8hfd_pkg::KIND_REMOTE_INPUT: begin
               unique case (rd_idx_ff)
                  3'd0: val_in[0] = {16'b0, w_hi, w_lo};
                  3'd1: val_in[1] = {16'b0, w_hi, w_lo};
                  3'd2: val_in[2] = {16'b0, w_hi, w_lo};
                  3'd3: begin
                     val_in[3] = {24'b0, w_lo};
                     val_in[4] = {24'b0, w_hi};
                  end
                  3'd4: val_in[5] = {16'b0, w_hi, w_lo};
                  default: ;
               endcase
            end
            crc8hfd_pkg::KIND_CENTER_GAIN: begin
               if (rd_idx_ff == 3'd1) begin
                  val_in[0] = {30'b0, w_hi[7:6]};
               end
            end
            default: ;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= crc8hfd_pkg::PH_HUNT;
         pos_ff        <= '0;
         len_ff        <= '0;
         crc_ff        <= crc8hfd_pkg::CRC8_SEED_RESET;
         hdr_good_ff   <= 1'b0;
         cmd_ff        <= '0;
         seed_ff       <= crc8hfd_pkg::CRC8_SEED_RESET;
         drain_busy_ff <= 1'b0;
         drain_cnt_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         crc_ff      <= crc_in;
         hdr_good_ff <= hdr_good_in;
         cmd_ff      <= cmd_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         if (drain_start) begin
            drain_busy_ff <= 1'b1;
            drain_cnt_ff  <= '0;
         end else if (drain_busy_ff) begin
            drain_cnt_ff <= drain_cnt_ff + 1'b1;
            if (drain_cnt_ff == DrainLast) begin
               drain_busy_ff <= 1'b0;
            end
         end
         rd_vld_ff <= drain_busy_ff;
         if (rd_vld_ff && (rd_idx_ff == DrainLast)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Memory and payload registers.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[mem_waddr] <= mem_wdata;
         if (!pay_idx[0]) begin
            lo_hold_ff <= rx_b;
         end
      end
      if (drain_busy_ff) begin
         rdata_ff  <= payload_mem[WordAw'(drain_cnt_ff)];
         rd_idx_ff <= drain_cnt_ff;
      end
      if (drain_start) begin
         kind_ff <= rec_sel.kind;
      end
      val_ff <= val_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{record_kind: kind_ff,
                        value_0: val_ff[0], value_1: val_ff[1], value_2: val_ff[2],
                        value_3: val_ff[3], value_4: val_ff[4], value_5: val_ff[5],
                        value_6: val_ff[6]};

   // A readout must never overwrite a record that is still on offer.
   a_drain_while_held: assert property (@(posedge clock) disable iff (reset)
      !((drain_busy_ff || rd_vld_ff) && rsp_valid_ff))
      else $error("payload readout overlaps a held record");

   // A record is offered only once its last word has been folded in.
   a_rsp_after_last_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(rd_vld_ff) && ($past(rd_idx_ff) == DrainLast)))
      else $error("record offered before its readout finished");

   // The next frame's payload writes must stay behind the readout.
   a_no_write_on_read_word: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && drain_busy_ff && (mem_waddr == WordAw'(drain_cnt_ff))))
      else $error("payload write hits the word being read out");

endmodule
